[design/rsp_pkg.sv]
// Shared types, codes and pixel expansion functions for the run-length sprite decoder.
package rsp_pkg;

	typedef enum logic [2:0] {
		PH_CTRL  = 3'd0,
		PH_SKIP  = 3'd1,
		PH_LOW   = 3'd2,
		PH_HIGH  = 3'd3,
		PH_ALPHA = 3'd4
	} phase_t;

	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_COLOUR = 2'd1;
	localparam logic [1:0] MODE_ALPHA  = 2'd2;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_DECODE_MODE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 4'd1;

	localparam logic [1:0]  DECODE_MODE_RESET = MODE_COLOUR;
	localparam logic [16:0] PIXEL_COUNT_RESET = 17'h10000;

	localparam logic [15:0] COLOUR_KEY = 16'hF81F;
	localparam logic [7:0]  SKIP_CODE  = 8'hFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_index;
		logic [31:0] pixel_value;
		logic        alpha_only;
		logic        out_of_range;
	} out_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] run;
		logic [7:0] low;
	} parse_state_t;

	function automatic logic [31:0] expand555(input logic [15:0] c);
		logic [31:0] v;
		v = 32'hFF00_0000;
		v[23:19] = c[14:10];
		v[18:16] = c[14:12];
		v[15:11] = c[9:5];
		v[9:8]   = c[9:8];
		v[7:3]   = c[4:0];
		v[2:0]   = c[4:2];
		return v;
	endfunction

	function automatic logic [31:0] expand_alpha(input logic [7:0] b);
		logic [31:0] v;
		v = '0;
		v[31:27] = b[4:0];
		v[26:24] = b[4:2];
		return v;
	endfunction

endpackage

[design/rsp_step.sv]
// Byte parser step: next parse state, next position and the pixel write for one byte.
module rsp_step #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic [1:0]                        mode,
	input  logic [16:0]                       pixel_count,
	input  rsp_pkg::parse_state_t             state,
	input  logic [$clog2(MAX_PIXELS+1)-1:0]   pos,
	input  rsp_pkg::in_item_t                 item,
	output rsp_pkg::parse_state_t             state_next,
	output logic [$clog2(MAX_PIXELS+1)-1:0]   pos_next,
	output logic                              emit,
	output rsp_pkg::out_item_t                result
);

	localparam int POS_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = POS_W + 1;
	localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
	localparam int CMP_W = (POS_W > 17) ? POS_W : 17;

	logic [7:0]       adv_amount;
	logic             adv_en;
	logic [SUM_W-1:0] sum;
	logic [POS_W-1:0] pos_adv;
	logic [15:0]      colour;
	logic [7:0]       run_dec;
	logic [EXT_W-1:0] pos_ext;
	logic [CMP_W-1:0] pos_cmp;
	logic [CMP_W-1:0] count_cmp;
	logic [CMP_W-1:0] bound;

	assign colour  = {item.data_byte, state.low};
	assign run_dec = state.run - 8'd1;

	assign sum     = SUM_W'(pos) + SUM_W'(adv_amount);
	assign pos_adv = (sum > SUM_W'(MAX_PIXELS)) ? POS_W'(MAX_PIXELS) : sum[POS_W-1:0];

	// Next parse state and position.
	always_comb begin
		state_next = state;
		adv_en     = 1'b0;
		adv_amount = 8'd1;
		case (mode)
			rsp_pkg::MODE_PLAIN: begin
				if (state.phase == rsp_pkg::PH_HIGH) begin
					adv_en           = 1'b1;
					state_next.phase = rsp_pkg::PH_CTRL;
				end else begin
					state_next.low   = item.data_byte;
					state_next.phase = rsp_pkg::PH_HIGH;
				end
			end
			rsp_pkg::MODE_COLOUR, rsp_pkg::MODE_ALPHA: begin
				case (state.phase)
					rsp_pkg::PH_SKIP: begin
						adv_en           = 1'b1;
						adv_amount       = item.data_byte;
						state_next.phase = rsp_pkg::PH_CTRL;
					end
					rsp_pkg::PH_LOW: begin
						state_next.low   = item.data_byte;
						state_next.phase = rsp_pkg::PH_HIGH;
					end
					rsp_pkg::PH_HIGH: begin
						adv_en           = 1'b1;
						state_next.run   = run_dec;
						state_next.phase = (run_dec == 8'd0) ? rsp_pkg::PH_CTRL
							: rsp_pkg::PH_LOW;
					end
					rsp_pkg::PH_ALPHA: begin
						adv_en           = 1'b1;
						state_next.run   = run_dec;
						state_next.phase = (run_dec == 8'd0) ? rsp_pkg::PH_CTRL
							: rsp_pkg::PH_ALPHA;
					end
					default: begin
						if (item.data_byte == rsp_pkg::SKIP_CODE) begin
							state_next.phase = rsp_pkg::PH_SKIP;
						end else if (item.data_byte == 8'd0) begin
							state_next.phase = rsp_pkg::PH_CTRL;
						end else begin
							state_next.run   = item.data_byte;
							state_next.phase = (mode == rsp_pkg::MODE_COLOUR)
								? rsp_pkg::PH_LOW : rsp_pkg::PH_ALPHA;
						end
					end
				endcase
			end
			default: begin
				state_next = state;
			end
		endcase
		pos_next = adv_en ? pos_adv : pos;
		if (item.last_byte) begin
			state_next.phase = rsp_pkg::PH_CTRL;
			state_next.run   = 8'd0;
			state_next.low   = 8'd0;
			pos_next         = '0;
		end
	end

	assign pos_ext   = EXT_W'(pos);
	assign pos_cmp   = CMP_W'(pos);
	assign count_cmp = CMP_W'(pixel_count);
	assign bound     = (count_cmp < CMP_W'(MAX_PIXELS)) ? count_cmp : CMP_W'(MAX_PIXELS);

	// Pixel write produced by this byte.
	always_comb begin
		emit                = 1'b0;
		result.pixel_index  = pos_ext[15:0];
		result.pixel_value  = rsp_pkg::expand555(colour);
		result.alpha_only   = 1'b0;
		result.out_of_range = (pos_cmp >= bound);
		case (mode)
			rsp_pkg::MODE_PLAIN, rsp_pkg::MODE_COLOUR, rsp_pkg::MODE_ALPHA: begin
				if (state.phase == rsp_pkg::PH_HIGH) begin
					emit = (colour != rsp_pkg::COLOUR_KEY);
				end else if (state.phase == rsp_pkg::PH_ALPHA &&
					mode != rsp_pkg::MODE_PLAIN) begin
					emit               = 1'b1;
					result.pixel_value = rsp_pkg::expand_alpha(item.data_byte);
					result.alpha_only  = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule

[design/rle_sprite_pixel_decoder.sv]
// Top level of the run-length sprite decoder: input stage, parse state, result register.
//
// The block takes an encoded sprite one byte per request on the byte channel
// (byte_valid, byte_ready, byte_data) and gives pixel writes on the pix channel
// (pix_valid, pix_ready, pix_data). Each byte causes at most one pixel write.
// Registers are written on the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); the user must write them only while the block is idle, and the
// block itself does not enforce this. Index 0 selects the decode mode and also
// restarts the stream, index 1 sets the pixel count. Other indices are ignored,
// and cfg_ready is always high. A byte is registered in an input stage and then
// parsed against the registered parse state; its pixel write is then registered
// in the result register. One byte per cycle is sustained unless pix_ready stalls.
// When the receiver stalls, the result register holds its request and the
// input stage fills; byte_ready then drops until pix_ready returns.
// Reset clears both stages, sets decode mode to colour run-length and the
// pixel count to 65536, and puts the parser at the start of a stream.
// A byte marked last_byte returns the parser and position to the start.
module rle_sprite_pixel_decoder #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	output logic                                 byte_ready,
	input  rsp_pkg::in_item_t                    byte_data,
	output logic                                 pix_valid,
	input  logic                                 pix_ready,
	output rsp_pkg::out_item_t                   pix_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rsp_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int POS_W = $clog2(MAX_PIXELS + 1);

	logic                  byte_valid_s1;
	rsp_pkg::in_item_t     byte_s1;
	logic                  pix_valid_q;
	rsp_pkg::out_item_t    pix_q;
	logic [1:0]            mode_q;
	logic [16:0]           count_q;
	rsp_pkg::parse_state_t state_q;
	logic [POS_W-1:0]      pos_q;

	rsp_pkg::parse_state_t state_next;
	logic [POS_W-1:0]      pos_next;
	logic                  emit;
	rsp_pkg::out_item_t    result;
	logic                  s1_fire;
	logic                  cfg_fire;
	logic                  mode_write;

	assign s1_fire    = byte_valid_s1 && (!pix_valid_q || pix_ready);
	assign byte_ready = !byte_valid_s1 || s1_fire;
	assign cfg_ready  = 1'b1;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign mode_write = cfg_fire && (cfg_index == rsp_pkg::REG_DECODE_MODE);
	assign pix_valid  = pix_valid_q;
	assign pix_data   = pix_q;

	rsp_step #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_step (
		.mode       (mode_q),
		.pixel_count(count_q),
		.state      (state_q),
		.pos        (pos_q),
		.item       (byte_s1),
		.state_next (state_next),
		.pos_next   (pos_next),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (s1_fire) begin
			pix_valid_q <= emit;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			pix_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rsp_pkg::DECODE_MODE_RESET;
			count_q <= rsp_pkg::PIXEL_COUNT_RESET;
		end else if (cfg_fire) begin
			if (cfg_index == rsp_pkg::REG_DECODE_MODE) begin
				mode_q <= cfg_data[1:0];
			end else if (cfg_index == rsp_pkg::REG_PIXEL_COUNT) begin
				count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= rsp_pkg::PH_CTRL;
			state_q.run   <= 8'd0;
			state_q.low   <= 8'd0;
			pos_q         <= '0;
		end else if (mode_write) begin
			state_q.phase <= rsp_pkg::PH_CTRL;
			state_q.run   <= 8'd0;
			state_q.low   <= 8'd0;
			pos_q         <= '0;
		end else if (s1_fire) begin
			state_q <= state_next;
			pos_q   <= pos_next;
		end
	end

`ifndef SYNTHESIS
	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_PIXELS))
		else $error("position exceeds the pixel limit");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (byte_valid_s1 && pix_valid_q && !pix_ready))
		else $error("input stalled without a blocked result");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && byte_s1.last_byte) |=>
		(state_q.phase == rsp_pkg::PH_CTRL && pos_q == '0))
		else $error("stream not restarted after the last byte");

	a_colour_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && !pix_q.alpha_only) |-> (pix_q.pixel_value[31:24] == 8'hFF))
		else $error("colour write without full alpha");

	a_alpha_lane_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid_q && pix_q.alpha_only) |-> (pix_q.pixel_value[23:0] == 24'd0))
		else $error("alpha write touches colour lanes");
`endif

endmodule

[bench/rle_sprite_pixel_decoder_checker.sv]
// Pixel write checker: follows the byte and register channels, predicts pixel writes and compares.
`timescale 1ns / 1ps

module rle_sprite_pixel_decoder_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	input  logic                                 byte_ready,
	input  rsp_pkg::in_item_t                    byte_data,
	input  logic                                 pix_valid,
	input  logic                                 pix_ready,
	input  rsp_pkg::out_item_t                   pix_data,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [rsp_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rsp_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                   pending_pixels,
	output int                                   mismatches
);

	localparam int unsigned PIXEL_LIMIT = 65536;
	localparam int PRINT_LIMIT = 200;

	logic [1:0]          decode_mode;
	logic [16:0]         pixel_total;
	rsp_pkg::phase_t     parse_phase;
	logic [7:0]          run_left;
	logic [7:0]          low_byte;
	int unsigned         pixel_pos;
	rsp_pkg::out_item_t  pending_writes[$];

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT) begin
			$display("[%0t] pixel mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	task automatic restart_stream();
		parse_phase = rsp_pkg::PH_CTRL;
		run_left = 8'd0;
		pixel_pos = 0;
		low_byte = 8'd0;
	endtask

	task automatic step_position(input int unsigned amount);
		pixel_pos = (pixel_pos + amount > PIXEL_LIMIT) ? PIXEL_LIMIT : pixel_pos + amount;
	endtask

	function automatic logic [31:0] rgb_from_555(input logic [15:0] colour);
		logic [31:0] c;
		c = {16'h0000, colour};
		return 32'hFF00_0000 | ((c & 32'h7C00) << 9) | ((c & 32'h7000) << 4)
			| ((c & 32'h03E0) << 6) | (c & 32'h0300)
			| ((c & 32'h001F) << 3) | ((c & 32'h001C) >> 2);
	endfunction

	function automatic logic [31:0] alpha_from_byte(input logic [7:0] level);
		logic [31:0] a;
		a = {24'h0, level};
		a = ((a & 32'h1F) << 3) | ((a & 32'h1C) >> 2);
		return a << 24;
	endfunction

	task automatic queue_pixel(input logic [31:0] value, input logic alpha);
		rsp_pkg::out_item_t item;
		int unsigned limit;
		limit = (32'(pixel_total) < PIXEL_LIMIT) ? 32'(pixel_total) : PIXEL_LIMIT;
		item.pixel_index = pixel_pos[15:0];
		item.pixel_value = value;
		item.alpha_only = alpha;
		item.out_of_range = (pixel_pos >= limit);
		pending_writes.push_back(item);
	endtask

	task automatic decode_byte(input rsp_pkg::in_item_t item);
		logic [15:0] colour;
		colour = {item.data_byte, low_byte};
		case (decode_mode)
			rsp_pkg::MODE_PLAIN: begin
				if (parse_phase == rsp_pkg::PH_HIGH) begin
					if (colour != rsp_pkg::COLOUR_KEY) queue_pixel(rgb_from_555(colour), 1'b0);
					step_position(1);
					parse_phase = rsp_pkg::PH_CTRL;
				end else begin
					low_byte = item.data_byte;
					parse_phase = rsp_pkg::PH_HIGH;
				end
			end
			rsp_pkg::MODE_COLOUR, rsp_pkg::MODE_ALPHA: begin
				case (parse_phase)
					rsp_pkg::PH_SKIP: begin
						step_position(32'(item.data_byte));
						parse_phase = rsp_pkg::PH_CTRL;
					end
					rsp_pkg::PH_LOW: begin
						low_byte = item.data_byte;
						parse_phase = rsp_pkg::PH_HIGH;
					end
					rsp_pkg::PH_HIGH: begin
						if (colour != rsp_pkg::COLOUR_KEY)
							queue_pixel(rgb_from_555(colour), 1'b0);
						step_position(1);
						run_left = run_left - 8'd1;
						parse_phase = (run_left == 8'd0) ? rsp_pkg::PH_CTRL : rsp_pkg::PH_LOW;
					end
					rsp_pkg::PH_ALPHA: begin
						queue_pixel(alpha_from_byte(item.data_byte), 1'b1);
						step_position(1);
						run_left = run_left - 8'd1;
						parse_phase = (run_left == 8'd0) ? rsp_pkg::PH_CTRL : rsp_pkg::PH_ALPHA;
					end
					default: begin
						if (item.data_byte == rsp_pkg::SKIP_CODE) begin
							parse_phase = rsp_pkg::PH_SKIP;
						end else if (item.data_byte == 8'd0) begin
							parse_phase = rsp_pkg::PH_CTRL;
						end else begin
							run_left = item.data_byte;
							parse_phase = (decode_mode == rsp_pkg::MODE_COLOUR)
								? rsp_pkg::PH_LOW : rsp_pkg::PH_ALPHA;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
		if (item.last_byte) restart_stream();
	endtask

	task automatic check_pixel(input rsp_pkg::out_item_t got);
		rsp_pkg::out_item_t want;
		if (pending_writes.size() == 0) begin
			report_mismatch($sformatf("unexpected write index %h value %h",
				got.pixel_index, got.pixel_value));
		end else begin
			want = pending_writes.pop_front();
			if (got.pixel_index != want.pixel_index)
				report_mismatch($sformatf("pixel_index %h, expected %h",
					got.pixel_index, want.pixel_index));
			if (got.pixel_value != want.pixel_value)
				report_mismatch($sformatf("pixel_value %h, expected %h at index %h",
					got.pixel_value, want.pixel_value, want.pixel_index));
			if (got.alpha_only != want.alpha_only)
				report_mismatch($sformatf("alpha_only %b, expected %b at index %h",
					got.alpha_only, want.alpha_only, want.pixel_index));
			if (got.out_of_range != want.out_of_range)
				report_mismatch($sformatf("out_of_range %b, expected %b at index %h",
					got.out_of_range, want.out_of_range, want.pixel_index));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode = rsp_pkg::DECODE_MODE_RESET;
			pixel_total = rsp_pkg::PIXEL_COUNT_RESET;
			restart_stream();
			pending_writes.delete();
			pending_pixels = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rsp_pkg::REG_DECODE_MODE) begin
					decode_mode = cfg_data[1:0];
					restart_stream();
				end else if (cfg_index == rsp_pkg::REG_PIXEL_COUNT) begin
					pixel_total = cfg_data;
				end
			end
			if (byte_valid && byte_ready) decode_byte(byte_data);
			if (pix_valid && pix_ready) check_pixel(pix_data);
			pending_pixels = pending_writes.size();
		end
	end

endmodule

[bench/rle_sprite_pixel_decoder_tb.sv]
// Top of the sprite decoder testbench: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module rle_sprite_pixel_decoder_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            byte_valid;
	logic                            byte_ready;
	rsp_pkg::in_item_t               byte_data;
	logic                            pix_valid;
	logic                            pix_ready = 1'b0;
	rsp_pkg::out_item_t              pix_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [rsp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data;

	int pending_pixels;
	int mismatches;
	int cycle_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int bytes_sent;
	int random_base;
	logic [1:0] current_mode;

	rle_sprite_pixel_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data(pix_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rle_sprite_pixel_decoder_checker pixel_checker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_data(byte_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix_data(pix_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending_pixels(pending_pixels),
		.mismatches(mismatches)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		pix_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_byte(input logic [7:0] value, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		byte_data.data_byte = value;
		byte_data.last_byte = last;
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		byte_valid = 1'b0;
		while (pending_pixels != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rsp_pkg::CFG_INDEX_W-1:0] index,
			input logic [rsp_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (index == rsp_pkg::REG_DECODE_MODE) current_mode = value[1:0];
	endtask

	function automatic logic [15:0] random_colour();
		if ($urandom_range(9) == 0) return rsp_pkg::COLOUR_KEY;
		return 16'($urandom_range(16'hFFFF));
	endfunction

	task automatic random_config();
		logic [rsp_pkg::CFG_DATA_W-1:0] value;
		int pick;
		if ($urandom_range(99) < 60) begin
			value = 17'($urandom_range(17'h1FFFF));
			value[1:0] = ($urandom_range(19) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
			write_reg(rsp_pkg::REG_DECODE_MODE, value);
		end
		if ($urandom_range(99) < 70) begin
			pick = $urandom_range(9);
			case (pick)
				0: value = 17'd0;
				1: value = 17'd1;
				2: value = rsp_pkg::PIXEL_COUNT_RESET;
				3: value = 17'h1FFFF;
				4, 5, 6: value = 17'($urandom_range(300, 1));
				default: value = 17'($urandom_range(17'h1FFFF));
			endcase
			write_reg(rsp_pkg::REG_PIXEL_COUNT, value);
		end
		if ($urandom_range(99) < 5) begin
			write_reg(4'($urandom_range(15, 2)), 17'($urandom_range(17'h1FFFF)));
		end
	endtask

	task automatic send_stream();
		logic [7:0] bytes[$];
		logic [15:0] colour;
		int segments;
		int pick;
		int run;
		int len;
		logic end_marked;
		segments = $urandom_range(6, 1);
		if ($urandom_range(99) < 5) begin
			len = $urandom_range(20, 1);
			repeat (len) begin
				pick = $urandom_range(255);
				bytes.push_back(pick[7:0]);
			end
		end else begin
			repeat (segments) begin
				if (current_mode == rsp_pkg::MODE_COLOUR
					|| current_mode == rsp_pkg::MODE_ALPHA) begin
					pick = $urandom_range(99);
					if (pick < 10) begin
						bytes.push_back(rsp_pkg::SKIP_CODE);
						run = $urandom_range(255);
						bytes.push_back(run[7:0]);
					end else if (pick < 15) begin
						bytes.push_back(8'd0);
					end else begin
						run = (pick < 20) ? $urandom_range(40, 9) : $urandom_range(8, 1);
						bytes.push_back(run[7:0]);
						repeat (run) begin
							if (current_mode == rsp_pkg::MODE_ALPHA) begin
								pick = $urandom_range(255);
								bytes.push_back(pick[7:0]);
							end else begin
								colour = random_colour();
								bytes.push_back(colour[7:0]);
								bytes.push_back(colour[15:8]);
							end
						end
					end
				end else begin
					colour = random_colour();
					bytes.push_back(colour[7:0]);
					bytes.push_back(colour[15:8]);
				end
			end
		end
		len = bytes.size();
		if ($urandom_range(99) < 10) len = $urandom_range(len, 1);
		end_marked = ($urandom_range(99) < 85);
		for (int i = 0; i < len; i++) begin
			send_byte(bytes[i], end_marked && (i == len - 1));
		end
	endtask

	task automatic run_directed();
		send_byte(8'h02, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(rsp_pkg::SKIP_CODE, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(rsp_pkg::COLOUR_KEY[7:0], 1'b0);
		send_byte(rsp_pkg::COLOUR_KEY[15:8], 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h1F, 1'b0);
		send_byte(8'h78, 1'b1);
		wait_quiet();
		write_reg(rsp_pkg::REG_DECODE_MODE, {15'd0, rsp_pkg::MODE_ALPHA});
		write_reg(rsp_pkg::REG_PIXEL_COUNT, 17'd2);
		send_byte(8'h03, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h1C, 1'b1);
		wait_quiet();
		write_reg(rsp_pkg::REG_DECODE_MODE, {15'd0, rsp_pkg::MODE_PLAIN});
		write_reg(rsp_pkg::REG_PIXEL_COUNT, 17'd0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(rsp_pkg::COLOUR_KEY[7:0], 1'b0);
		send_byte(rsp_pkg::COLOUR_KEY[15:8], 1'b0);
		send_byte(8'hAB, 1'b1);
		wait_quiet();
		write_reg(rsp_pkg::REG_DECODE_MODE, {15'd0, MODE_UNUSED});
		write_reg(rsp_pkg::REG_PIXEL_COUNT, 17'h1FFFF);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		wait_quiet();
	endtask

	task automatic run_position_overflow();
		logic [15:0] colour;
		wait_quiet();
		write_reg(rsp_pkg::REG_DECODE_MODE, {15'd0, rsp_pkg::MODE_COLOUR});
		write_reg(rsp_pkg::REG_PIXEL_COUNT, rsp_pkg::PIXEL_COUNT_RESET);
		repeat (257) begin
			send_byte(rsp_pkg::SKIP_CODE, 1'b0);
			send_byte(8'hFF, 1'b0);
		end
		send_byte(8'h03, 1'b0);
		for (int i = 0; i < 3; i++) begin
			colour = random_colour();
			send_byte(colour[7:0], 1'b0);
			send_byte(colour[15:8], i == 2);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		cfg_valid = 1'b0;
		cfg_index = rsp_pkg::REG_DECODE_MODE;
		cfg_data = '0;
		bytes_sent = 0;
		current_mode = rsp_pkg::DECODE_MODE_RESET;
		send_idle_pct = 15;
		recv_idle_pct = 52;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		random_base = bytes_sent;
		for (int stage = 0; stage < 3; stage++) begin
			if (stage == 1) begin
				send_idle_pct = 52;
				recv_idle_pct = 15;
			end else if (stage == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				run_position_overflow();
			end
			while (bytes_sent < random_base + ((stage == 2) ? 1000 : (stage + 1) * 160)) begin
				if ($urandom_range(99) < 30) begin
					wait_quiet();
					random_config();
				end
				send_stream();
			end
		end

		wait_quiet();
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
